### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, cond, expr)
`endif

`endif

### sv/nplk_pkg.sv
package nplk_pkg;

   localparam int ADDR_W      = 15;
   localparam int MAX_ENTRIES = 1 << ADDR_W;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [ADDR_W:0]   wide_type;

   localparam addr_type LIMIT_RESET = addr_type'(21000);
   localparam addr_type FIRST_PRIME = addr_type'(2);

endpackage

### sv/next_prime_lookup.sv
// next_prime_lookup: answers "smallest prime at or above n" from a prime
// bitmap held in one 1-bit-wide synchronous RAM of 32768 entries. After reset
// and after every write of the limit word the block rebuilds the bitmap with
// the Sieve of Eratosthenes and takes no queries (req_stall high) until it is
// done: a fill pass over entries 0 to limit, then for each p with p*p <= limit
// a test of p and, if p is still marked prime, a strike of each multiple of p
// from p*p up to the limit, and a closing step once p*p exceeds the limit.
// A query then scans the RAM upward one entry per cycle through its single
// read port, from the query up to next_prime (or up to the limit when none is
// found); a query above the limit is answered without scanning the bitmap.
// One query is in flight at a time; a finished answer sits in the output
// register so the next query can be accepted while rsp_valid waits on
// rsp_stall. found is 0 (next_prime 0) when no prime lies between the query
// and the limit.
`include "assert_macros.svh"

module next_prime_lookup (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nplk_pkg::addr_type req_query_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nplk_pkg::addr_type rsp_next_prime,
   output logic              rsp_query_is_prime,
   output logic              rsp_found,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  nplk_pkg::addr_type csr_limit
);
   import nplk_pkg::*;

   typedef enum logic [2:0] {
      S_FILL,
      S_P_ISSUE,
      S_P_TEST,
      S_STRIKE,
      S_IDLE,
      S_SCAN
   } state_type;

   localparam wide_type FIRST_SQ = wide_type'(FIRST_PRIME) * wide_type'(FIRST_PRIME);

   state_type state_ff, state_in;
   addr_type  limit_ff, limit_in;
   addr_type  fill_ff, fill_in;      // fill pass address
   addr_type  p_ff, p_in;            // sieve candidate
   wide_type  sq_ff, sq_in;          // p*p, kept incrementally
   wide_type  m_ff, m_in;            // multiple being struck
   addr_type  chk_ff, chk_in;        // address whose data is in rd_data_ff
   logic      first_ff, first_in;
   logic      over_ff, over_in;
   logic      isp_ff, isp_in;

   logic      rsp_valid_ff, rsp_valid_in;
   addr_type  rsp_np_ff, rsp_np_in;
   logic      rsp_isp_ff, rsp_isp_in;
   logic      rsp_fnd_ff, rsp_fnd_in;

   // bitmap RAM
   logic      mem [MAX_ENTRIES];
   logic      rd_data_ff;
   addr_type  mem_raddr;
   addr_type  mem_waddr;
   logic      mem_we;
   logic      mem_wdata;

   logic      req_accept;
   logic      slot_free;
   logic      scan_hit;
   logic      scan_end;
   logic      scan_load;
   logic      isp_now;
   wide_type  m_next;
   wide_type  limit_wide;

   assign limit_wide = {1'b0, limit_ff};
   assign m_next     = m_ff + {1'b0, p_ff};

   // a pending config write takes priority over a query in the same cycle
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE) || csr_valid;
   assign req_accept = req_valid && !req_stall;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_hit   = rd_data_ff && !over_ff;
   assign scan_end   = scan_hit || over_ff || (chk_ff == limit_ff);
   assign scan_load  = (state_ff == S_SCAN) && scan_end && slot_free;
   assign isp_now    = first_ff ? (rd_data_ff && !over_ff) : isp_ff;

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      fill_in      = fill_ff;
      p_in         = p_ff;
      sq_in        = sq_ff;
      m_in         = m_ff;
      chk_in       = chk_ff;
      first_in     = first_ff;
      over_in      = over_ff;
      isp_in       = isp_ff;
      rsp_np_in    = rsp_np_ff;
      rsp_isp_in   = rsp_isp_ff;
      rsp_fnd_in   = rsp_fnd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_raddr    = p_ff;
      mem_waddr    = fill_ff;
      mem_we       = 1'b0;
      mem_wdata    = 1'b0;

      unique case (state_ff)
         S_FILL: begin
            // 0 and 1 are not prime, everything else up to the limit starts as prime
            mem_we    = 1'b1;
            mem_waddr = fill_ff;
            mem_wdata = (fill_ff >= FIRST_PRIME);
            fill_in   = fill_ff + addr_type'(1);
            if (fill_ff == limit_ff) begin
               p_in     = FIRST_PRIME;
               sq_in    = FIRST_SQ;
               state_in = S_P_ISSUE;
            end
         end
         S_P_ISSUE: begin
            mem_raddr = p_ff;
            if (sq_ff > limit_wide) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_P_TEST;
            end
         end
         S_P_TEST: begin
            if (rd_data_ff) begin
               m_in     = sq_ff;
               state_in = S_STRIKE;
            end else begin
               p_in     = p_ff + addr_type'(1);
               sq_in    = sq_ff + {p_ff, 1'b1};
               state_in = S_P_ISSUE;
            end
         end
         S_STRIKE: begin
            mem_we    = 1'b1;
            mem_waddr = m_ff[ADDR_W-1:0];
            mem_wdata = 1'b0;
            m_in      = m_next;
            if (m_next > limit_wide) begin
               p_in     = p_ff + addr_type'(1);
               sq_in    = sq_ff + {p_ff, 1'b1};
               state_in = S_P_ISSUE;
            end
         end
         S_IDLE: begin
            mem_raddr = req_query_value;
            if (csr_valid) begin
               limit_in = csr_limit;
               fill_in  = '0;
               state_in = S_FILL;
            end else if (req_accept) begin
               chk_in   = req_query_value;
               first_in = 1'b1;
               over_in  = (req_query_value > limit_ff);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // advance one entry a cycle; hold the address while the answer waits
            mem_raddr = scan_end ? chk_ff : (chk_ff + addr_type'(1));
            isp_in    = isp_now;
            first_in  = 1'b0;
            if (!scan_end) begin
               chk_in = chk_ff + addr_type'(1);
            end
            if (scan_load) begin
               rsp_valid_in = 1'b1;
               rsp_np_in    = scan_hit ? chk_ff : '0;
               rsp_isp_in   = isp_now;
               rsp_fnd_in   = scan_hit;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         limit_ff     <= LIMIT_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      sq_ff      <= sq_in;
      m_ff       <= m_in;
      chk_ff     <= chk_in;
      first_ff   <= first_in;
      over_ff    <= over_in;
      isp_ff     <= isp_in;
      rsp_np_ff  <= rsp_np_in;
      rsp_isp_ff <= rsp_isp_in;
      rsp_fnd_ff <= rsp_fnd_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_prime     = rsp_np_ff;
   assign rsp_query_is_prime = rsp_isp_ff;
   assign rsp_found          = rsp_fnd_ff;

   `ASSERT_IMPLIES(a_found_in_range, clock, reset, rsp_valid_ff && rsp_fnd_ff,
      (rsp_np_ff >= FIRST_PRIME) && (rsp_np_ff <= limit_ff))
   `ASSERT_IMPLIES(a_miss_is_zero, clock, reset, rsp_valid_ff && !rsp_fnd_ff,
      rsp_np_ff == '0)
   `ASSERT_IMPLIES(a_prime_query_found, clock, reset, rsp_valid_ff && rsp_isp_ff,
      rsp_fnd_ff)
   `ASSERT_IMPLIES(a_strike_in_range, clock, reset, state_ff == S_STRIKE,
      (m_ff <= limit_wide) && (m_ff >= FIRST_SQ))
   `ASSERT_HOLDS(a_scan_bounded, clock, reset,
      (state_ff != S_SCAN) || over_ff || (chk_ff <= limit_ff))

endmodule
